// ===== rtl/core/lzss_pkg.sv =====
`default_nettype none

package lzss_pkg;

  // history window geometry
  localparam int unsigned WIN_AW = 12;
  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned CNT_W = 27;

  // reset value of the size limit register (64 MiB)
  localparam logic [CNT_W-1:0] SIZE_LIMIT_RST = 27'h4000000;

  // block status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR    = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE    = 3'd3;
  localparam logic [2:0] ST_TRUNC_REF    = 3'd4;
  localparam logic [2:0] ST_BAD_DIST     = 3'd5;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd6;

  // work handed from the parser to the copy engine for one input word
  typedef struct packed {
    logic                  lit;
    logic                  copy;
    logic                  done;
    logic [7:0]            lit_byte;
    logic [WIN_AW-1:0]     offset;
    logic [3:0]            len_m1;
    logic [2:0]            status;
  } job_t;

  // header magic "LZSS"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h4C;
      2'd1:    b = 8'h5A;
      2'd2:    b = 8'h53;
      default: b = 8'h53;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lzss_parse.sv =====
`default_nettype none

module lzss_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [7:0]                  byte_i,
  input  wire logic                        last_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic [lzss_pkg::CNT_W-1:0]  cfg_data_i,
  output lzss_pkg::job_t                   job_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CMD,
    PH_ITEM,
    PH_REF2,
    PH_DONE
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [2:0]                   hdr_cnt_q, hdr_cnt_d;
  logic [31:0]                  decl_q, decl_d;
  logic [7:0]                   flag_q, flag_d;
  logic [2:0]                   flag_cnt_q, flag_cnt_d;
  logic [7:0]                   first_q, first_d;
  logic [lzss_pkg::CNT_W-1:0]   count_q, count_d;
  logic [2:0]                   err_q, err_d;
  logic [lzss_pkg::CNT_W-1:0]   limit_q;

  logic [lzss_pkg::WIN_AW-1:0]  ref_off;
  logic [4:0]                   nbytes;
  logic [lzss_pkg::CNT_W:0]     count_sum;
  logic [2:0]                   status;

  assign ref_off = {first_q, byte_i[7:4]};

  // decode one compressed byte
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    decl_d     = decl_q;
    flag_d     = flag_q;
    flag_cnt_d = flag_cnt_q;
    first_d    = first_q;
    err_d      = err_q;
    nbytes     = 5'd0;
    count_sum  = '0;
    status     = lzss_pkg::ST_OK;
    count_d    = count_q;
    job_o      = '0;

    if (accept_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (!hdr_cnt_q[2]) begin
            if (byte_i != lzss_pkg::magic_byte(hdr_cnt_q[1:0])) begin
              err_d = lzss_pkg::ST_BAD_MAGIC;
            end
          end else begin
            unique case (hdr_cnt_q[1:0])
              2'd0:    decl_d[7:0]   = decl_q[7:0] | byte_i;
              2'd1:    decl_d[15:8]  = decl_q[15:8] | byte_i;
              2'd2:    decl_d[23:16] = decl_q[23:16] | byte_i;
              default: decl_d[31:24] = decl_q[31:24] | byte_i;
            endcase
          end
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_cnt_q == 3'd7) begin
            if (err_d == lzss_pkg::ST_OK &&
                decl_d > {{(32-lzss_pkg::CNT_W){1'b0}}, limit_q}) begin
              err_d = lzss_pkg::ST_TOO_LARGE;
            end
            phase_d = (err_d != lzss_pkg::ST_OK) ? PH_DONE : PH_CMD;
          end else if (last_i) begin
            err_d = lzss_pkg::ST_SHORT_HDR;
          end
        end
        PH_CMD: begin
          flag_d  = byte_i;
          phase_d = PH_ITEM;
          if (last_i && byte_i[0]) begin
            err_d = lzss_pkg::ST_TRUNC_REF;
          end
        end
        PH_ITEM: begin
          if (flag_q[0]) begin
            first_d = byte_i;
            phase_d = PH_REF2;
            if (last_i) begin
              err_d = lzss_pkg::ST_TRUNC_REF;
            end
          end else begin
            job_o.lit      = 1'b1;
            job_o.lit_byte = byte_i;
            nbytes         = 5'd1;
            flag_d         = flag_q >> 1;
            flag_cnt_d     = flag_cnt_q + 3'd1;
            phase_d        = (flag_cnt_d == 3'd0) ? PH_CMD : PH_ITEM;
          end
        end
        PH_REF2: begin
          if (byte_i[3:0] == 4'd0) begin
            // end marker
            phase_d = PH_DONE;
          end else if ({{(lzss_pkg::CNT_W-lzss_pkg::WIN_AW-1){1'b0}},
                        {1'b0, ref_off} + 13'd1} > count_q) begin
            err_d   = lzss_pkg::ST_BAD_DIST;
            phase_d = PH_DONE;
          end else begin
            job_o.copy   = 1'b1;
            job_o.offset = ref_off;
            job_o.len_m1 = byte_i[3:0];
            nbytes       = {1'b0, byte_i[3:0]} + 5'd1;
            flag_d       = flag_q >> 1;
            flag_cnt_d   = flag_cnt_q + 3'd1;
            phase_d      = (flag_cnt_d == 3'd0) ? PH_CMD : PH_ITEM;
          end
        end
        default: begin
        end
      endcase

      // saturating output count
      count_sum = {1'b0, count_q} + {{(lzss_pkg::CNT_W-4){1'b0}}, nbytes};
      count_d   = count_sum[lzss_pkg::CNT_W] ? '1 : count_sum[lzss_pkg::CNT_W-1:0];

      // block end: status word and clear of block state
      if (last_i) begin
        status = err_d;
        if (status == lzss_pkg::ST_OK &&
            {{(32-lzss_pkg::CNT_W){1'b0}}, count_d} != decl_d) begin
          status = lzss_pkg::ST_LEN_MISMATCH;
        end
        job_o.done   = 1'b1;
        job_o.status = status;
        phase_d      = PH_HEADER;
        hdr_cnt_d    = '0;
        decl_d       = '0;
        flag_d       = '0;
        flag_cnt_d   = '0;
        first_d      = '0;
        count_d      = '0;
        err_d        = lzss_pkg::ST_OK;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      decl_q     <= '0;
      flag_q     <= '0;
      flag_cnt_q <= '0;
      first_q    <= '0;
      count_q    <= '0;
      err_q      <= lzss_pkg::ST_OK;
      limit_q    <= lzss_pkg::SIZE_LIMIT_RST;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      decl_q     <= decl_d;
      flag_q     <= flag_d;
      flag_cnt_q <= flag_cnt_d;
      first_q    <= first_d;
      count_q    <= count_d;
      err_q      <= err_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lzss_engine.sv =====
`default_nettype none

module lzss_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire lzss_pkg::job_t  job_i,
  output logic                 job_ready_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output logic [15:0]          m_tdata_o,
  output logic [1:0]           m_tuser_o,
  output logic                 m_tlast_o
);

  localparam int unsigned AW = lzss_pkg::WIN_AW;

  // history window
  logic [7:0]    hist_mem [lzss_pkg::WIN_DEPTH];
  logic [7:0]    rdata_q;

  // pending work of the current job
  logic          lit_q, copy_q, done_q;
  logic [7:0]    lit_byte_q;
  logic [3:0]    cnt_q;
  logic [AW-1:0] rd_addr_q;
  logic [2:0]    status_q;
  logic [AW-1:0] ip_q;

  // data stage (between memory read and output register)
  logic          dv_q;
  logic          d_mem_q;
  logic          d_status_q;
  logic [7:0]    d_byte_q;
  logic [2:0]    d_st_q;
  logic [AW-1:0] d_waddr_q;
  logic          d_last_q;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;

  // output register
  logic          ov_q;
  logic [7:0]    o_byte_q;
  logic          o_bv_q;
  logic          o_done_q;
  logic [2:0]    o_st_q;
  logic          o_last_q;

  logic          out_free, d_move, d_free, mem_we, fwd_hit;
  logic          push_lit, push_rd, push_st;
  logic [7:0]    d_data;

  // stage handshakes and issue selection
  always_comb begin
    out_free    = !ov_q || m_tready_i;
    d_move      = dv_q && out_free;
    d_data      = d_mem_q ? (fwd_q ? fwd_data_q : rdata_q) : d_byte_q;
    d_free      = !dv_q || d_move;
    mem_we      = d_move && !d_status_q;
    fwd_hit     = mem_we && (d_waddr_q == rd_addr_q);
    push_lit    = d_free && lit_q;
    push_rd     = d_free && !lit_q && copy_q;
    push_st     = d_free && !lit_q && !copy_q && done_q;
    job_ready_o = !lit_q && !copy_q && !done_q;
  end

  // window write on retire, registered read on issue
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[d_waddr_q] <= d_data;
    end
    if (push_rd) begin
      rdata_q <= hist_mem[rd_addr_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q     <= 1'b0;
      copy_q    <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      ip_q      <= '0;
      dv_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (job_valid_i && job_ready_o) begin
        lit_q     <= job_i.lit;
        copy_q    <= job_i.copy;
        done_q    <= job_i.done;
        cnt_q     <= job_i.len_m1;
        rd_addr_q <= ip_q - job_i.offset - {{(AW-1){1'b0}}, 1'b1};
      end else begin
        if (push_lit) begin
          lit_q <= 1'b0;
        end
        if (push_rd) begin
          if (cnt_q == '0) begin
            copy_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
          rd_addr_q <= rd_addr_q + {{(AW-1){1'b0}}, 1'b1};
        end
        if (push_st) begin
          done_q <= 1'b0;
        end
      end
      // write pointer restarts with each block
      if (push_lit || push_rd) begin
        ip_q <= ip_q + {{(AW-1){1'b0}}, 1'b1};
      end else if (push_st) begin
        ip_q <= '0;
      end
      if (push_lit || push_rd || push_st) begin
        dv_q <= 1'b1;
      end else if (d_move) begin
        dv_q <= 1'b0;
      end
      if (out_free) begin
        ov_q <= d_move;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      lit_byte_q <= job_i.lit_byte;
      status_q   <= job_i.status;
    end
    if (push_lit) begin
      d_mem_q    <= 1'b0;
      d_status_q <= 1'b0;
      d_byte_q   <= lit_byte_q;
      d_waddr_q  <= ip_q;
      d_last_q   <= !done_q;
    end else if (push_rd) begin
      d_mem_q    <= 1'b1;
      d_status_q <= 1'b0;
      d_waddr_q  <= ip_q;
      d_last_q   <= (cnt_q == '0) && !done_q;
      fwd_q      <= fwd_hit;
      fwd_data_q <= d_data;
    end else if (push_st) begin
      d_mem_q    <= 1'b0;
      d_status_q <= 1'b1;
      d_st_q     <= status_q;
      d_last_q   <= 1'b1;
    end
    if (d_move) begin
      o_byte_q <= d_status_q ? 8'd0 : d_data;
      o_bv_q   <= !d_status_q;
      o_done_q <= d_status_q;
      o_st_q   <= d_status_q ? d_st_q : lzss_pkg::ST_OK;
      o_last_q <= d_last_q;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {5'd0, o_st_q, o_byte_q};
  assign m_tuser_o  = {o_done_q, o_bv_q};
  assign m_tlast_o  = o_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/lzss_block_decompressor.sv =====
// lzss block decompressor
// s_axis takes one compressed byte per word, header included; tlast marks
// the final byte of a compressed block. m_axis gives decompressed bytes and,
// at the end of each block, one status word; tlast marks the last word
// caused by an input word. cfg_* writes the size limit (resets to 64 MiB);
// it is to be written by the user only while the block is idle; the block does not enforce this.
// Timing: an input word is decoded in the cycle it is accepted and its work
// is registered in the copy engine; its output words then pass a window read
// stage and an output register, one per cycle while m_axis is ready, with
// reference bytes read through the single read port of the 4096-byte
// history memory. The next input word is taken once all words of the
// previous one have been issued to the read stage.
// Reset clears all control state; the history memory is not cleared, as
// the distance check never lets a reference reach an unwritten entry.
// A stalled receiver holds the output register and the read stage; input
// is then held off as soon as the pending work cannot advance.
`default_nettype none

module lzss_block_decompressor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic [1:0]                       m_axis_tuser,   // [0] byte_valid, [1] block_done
  output logic                             m_axis_tlast,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lzss_pkg::CNT_W-1:0]  cfg_data_i
);

  lzss_pkg::job_t job;
  logic           job_ready;
  logic           accept;

  assign s_axis_tready = job_ready;
  assign accept        = s_axis_tvalid && job_ready;
  assign cfg_ready_o   = 1'b1;

  // command decoder
  lzss_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .job_o       (job)
  );

  // history window and copy engine
  lzss_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (accept),
    .job_i       (job),
    .job_ready_o (job_ready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

  // a status word always closes the run of its input word
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("status word without tlast or with a byte flag");

  // a byte word carries no status
  a_byte_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[10:8] == lzss_pkg::ST_OK)
    else $error("byte word with non-zero status");

  // a block-end input always yields work, so input stalls the next cycle
  a_end_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken while a status word is pending");

endmodule

`default_nettype wire
